// File: rtl/tsl_pkg.sv
// Shared types, calendar constants and reciprocal multipliers for the
// timestamp to fixed local time converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsl_pkg;

  localparam int EPOCH_YEAR   = 1970;
  localparam int SECS_PER_DAY = 86400;
  localparam int MINS_PER_DAY = 1440;

  localparam logic signed [11:0] RESET_LOCAL_OFFSET = -12'sd360;

  // Bias that turns the positive day terms into days since 1970-01-01.
  // It folds the floor-division offsets of the leap counts and the day-1 term.
  localparam int DAYS_BIAS = EPOCH_YEAR * 365 + 493 - 20 + 5 + 1;

  // Shift of the day number so that eras start on March 1st of year 0.
  localparam int ERA_SHIFT_DAYS = 719468;
  localparam int DAYS_PER_ERA   = 146097;

  // Division by a constant d for inputs below 2^X uses m = ceil(2^k / d)
  // with k = X + ceil(log2 d), which is exact over the whole input range.
  localparam int unsigned DIV60_K = 23;  // 17-bit second of day
  localparam logic [21:0] DIV60_M = 22'(((64'd1 << DIV60_K) + 64'd59) / 64'd60);
  localparam int unsigned HOUR_K = 17;   // 11-bit minute of day
  localparam logic [21:0] HOUR_M = 22'(((64'd1 << HOUR_K) + 64'd59) / 64'd60);
  localparam int unsigned ERA_K = 39;    // 21-bit shifted day number
  localparam logic [21:0] ERA_M = 22'(((64'd1 << ERA_K) + 64'd146096) / 64'd146097);
  localparam int unsigned D1460_K = 29;  // 18-bit day of era
  localparam logic [21:0] D1460_M = 22'(((64'd1 << D1460_K) + 64'd1459) / 64'd1460);
  localparam int unsigned D36524_K = 34;
  localparam logic [21:0] D36524_M = 22'(((64'd1 << D36524_K) + 64'd36523) / 64'd36524);
  localparam int unsigned D365_K = 27;
  localparam logic [21:0] D365_M = 22'(((64'd1 << D365_K) + 64'd364) / 64'd365);
  localparam int unsigned YOE100_K = 17; // 10-bit year of era
  localparam logic [21:0] YOE100_M = 22'(((64'd1 << YOE100_K) + 64'd99) / 64'd100);
  localparam int unsigned MP_K = 19;     // 11-bit month index numerator
  localparam logic [21:0] MP_M = 22'(((64'd1 << MP_K) + 64'd152) / 64'd153);
  localparam int unsigned D5_K = 14;
  localparam logic [21:0] D5_M = 22'(((64'd1 << D5_K) + 64'd4) / 64'd5);
  localparam int unsigned Y100_K = 20;   // 13-bit year terms
  localparam logic [21:0] Y100_M = 22'(((64'd1 << Y100_K) + 64'd99) / 64'd100);
  localparam int unsigned Y400_K = 22;
  localparam logic [21:0] Y400_M = 22'(((64'd1 << Y400_K) + 64'd399) / 64'd400);

  typedef struct packed {
    logic [16:0] secs;
    logic        clamped;
  } sod_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // Quotient of x by the divisor whose scaled reciprocal is m / 2^k.
  function automatic logic [42:0] recip_mul(input logic [20:0] x, input logic [21:0] m,
                                            input int unsigned k);
    logic [42:0] p;
    p = 43'(x) * 43'(m);
    return p >> k;
  endfunction

  // Days before the first of the month in a common year; codes that name
  // no month add nothing.
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tsl_day_count.sv
// Two-stage front end: days since 1970 from the calendar date, and the
// signed second of that day after both offsets. Uses tsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsl_day_count #(
  parameter int MAX_YEAR = 2399
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [11:0]        year,
  input  wire logic [3:0]         month,
  input  wire logic [4:0]         day,
  input  wire logic [4:0]         hour,
  input  wire logic [5:0]         minute,
  input  wire logic [5:0]         second,
  input  wire logic signed [11:0] src_offset,
  input  wire logic signed [11:0] local_offset,
  output logic signed [21:0]      days,
  output logic signed [19:0]      sod
);

  localparam logic [13:0] YEAR_CAP = 14'(MAX_YEAR);

  // Stage A registers.
  logic [11:0]        ya;
  logic [3:0]         montha;
  logic [4:0]         daya;
  logic [10:0]        q4a;
  logic [6:0]         q100pa;
  logic [4:0]         q400pa;
  logic [5:0]         q100a;
  logic signed [19:0] soda;

  logic [11:0]        ya_next;
  logic [10:0]        q4_next;
  logic [6:0]         q100p_next;
  logic [4:0]         q400p_next;
  logic [5:0]         q100_next;
  logic signed [19:0] sod_next;
  logic signed [21:0] days_next;

  always_comb begin
    logic [42:0]        p100p;
    logic [42:0]        p400p;
    logic [42:0]        p100;
    logic [16:0]        pos;
    logic signed [12:0] dif;
    logic signed [18:0] off60;
    ya_next    = ({2'b00, year} > YEAR_CAP) ? YEAR_CAP[11:0] : year;
    q4_next    = 11'((13'(ya_next) + 13'd3) >> 2);
    p100p      = tsl_pkg::recip_mul(21'(13'(ya_next) + 13'd99), tsl_pkg::Y100_M,
                                    tsl_pkg::Y100_K);
    p400p      = tsl_pkg::recip_mul(21'(13'(ya_next) + 13'd399), tsl_pkg::Y400_M,
                                    tsl_pkg::Y400_K);
    p100       = tsl_pkg::recip_mul(21'(ya_next), tsl_pkg::Y100_M, tsl_pkg::Y100_K);
    q100p_next = p100p[6:0];
    q400p_next = p400p[4:0];
    q100_next  = p100[5:0];
    pos        = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
    dif        = $signed({local_offset[11], local_offset}) -
                 $signed({src_offset[11], src_offset});
    off60      = 19'(dif) * 19'sd60;
    sod_next   = $signed({3'b000, pos}) + $signed({off60[18], off60});
  end

  always_comb begin
    logic [11:0] r100;
    logic        leap;
    logic        leap_add;
    logic [21:0] pos_sum;
    logic [21:0] neg_sum;
    r100      = ya - 12'(q100a) * 12'd100;
    leap      = (ya[1:0] == 2'b00) && ((r100[6:0] != 7'd0) || (q100a[1:0] == 2'b00));
    leap_add  = leap && (montha > 4'd2);
    pos_sum   = 22'(ya) * 22'd365 + 22'(q4a) + 22'(q400pa) +
                22'(tsl_pkg::month_start(montha)) + 22'(daya) + 22'(leap_add);
    neg_sum   = 22'(q100pa) + 22'(tsl_pkg::DAYS_BIAS);
    days_next = $signed(pos_sum - neg_sum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ya     <= ya_next;
      montha <= month;
      daya   <= day;
      q4a    <= q4_next;
      q100pa <= q100p_next;
      q400pa <= q400p_next;
      q100a  <= q100_next;
      soda   <= sod_next;
      days   <= days_next;
      sod    <= soda;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tsl_normalize.sv
// One stage that folds the second of day into whole days and clamps a
// local time before the epoch. Uses tsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsl_normalize (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [21:0] days,
  input  wire logic signed [19:0] sod,
  output logic [19:0]             dn,
  output tsl_pkg::sod_t           side
);

  logic [19:0]   dn_next;
  tsl_pkg::sod_t side_next;

  // The second of day stays within a few days of zero, so the whole-day
  // carry comes from a row of compares against multiples of a day.
  always_comb begin
    logic [2:0]         passed;
    logic signed [19:0] thr;
    logic signed [3:0]  dq;
    logic signed [19:0] sod_mod;
    logic signed [21:0] tot;
    passed = 3'd0;
    for (int i = 0; i < 7; i++) begin
      thr = 20'((i - 2) * tsl_pkg::SECS_PER_DAY);
      if (sod >= thr) begin
        passed = passed + 3'd1;
      end
    end
    dq                = $signed({1'b0, passed}) - 4'sd3;
    sod_mod           = sod - 20'(32'(dq) * tsl_pkg::SECS_PER_DAY);
    tot               = days + 22'(dq);
    dn_next           = tot[21] ? 20'd0 : tot[19:0];
    side_next.secs    = tot[21] ? 17'd0 : sod_mod[16:0];
    side_next.clamped = tot[21];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn   <= dn_next;
      side <= side_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tsl_civil_date.sv
// Ten-stage conversion of a day number since 1970 into year, month and day,
// with the second of day carried alongside. Uses tsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsl_civil_date (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [19:0]    dn,
  input  wire tsl_pkg::sod_t  side_in,
  output tsl_pkg::date_t      date,
  output tsl_pkg::sod_t       side_out
);

  localparam int STAGES = 10;

  tsl_pkg::sod_t side_q [STAGES];

  logic [20:0] c1_z;
  logic [3:0]  c1_era;
  logic [17:0] c2_doe;
  logic [3:0]  c2_era;
  logic [17:0] c3_doe;
  logic [3:0]  c3_era;
  logic [7:0]  c3_q1460;
  logic [2:0]  c3_q36524;
  logic        c3_full;
  logic [17:0] c4_num;
  logic [17:0] c4_doe;
  logic [3:0]  c4_era;
  logic [9:0]  c5_yoe;
  logic [17:0] c5_doe;
  logic [3:0]  c5_era;
  logic [9:0]  c6_yoe;
  logic [17:0] c6_doe;
  logic [3:0]  c6_era;
  logic [3:0]  c6_q100;
  logic [8:0]  c7_doy;
  logic [13:0] c7_yr;
  logic [8:0]  c8_doy;
  logic [3:0]  c8_mp;
  logic [13:0] c8_yr;
  logic [8:0]  c9_doy;
  logic [8:0]  c9_d5;
  logic [3:0]  c9_mm;
  logic [13:0] c9_yr;

  logic [20:0]    z_next;
  logic [3:0]     era_next;
  logic [17:0]    doe_next;
  logic [7:0]     q1460_next;
  logic [2:0]     q36524_next;
  logic           full_next;
  logic [17:0]    num_next;
  logic [9:0]     yoe_next;
  logic [3:0]     q100_next;
  logic [8:0]     doy_next;
  logic [13:0]    yr_next;
  logic [3:0]     mp_next;
  logic [8:0]     d5_next;
  logic [3:0]     mm_next;
  tsl_pkg::date_t date_next;

  always_comb begin
    logic [42:0] p_era;
    logic [42:0] p1460;
    logic [42:0] p36524;
    logic [42:0] p365;
    logic [42:0] p100;
    logic [42:0] pmp;
    logic [42:0] pd5;
    logic [17:0] base;
    logic [13:0] yr_adj;
    // Era and day of era.
    z_next      = 21'(dn) + 21'(tsl_pkg::ERA_SHIFT_DAYS);
    p_era       = tsl_pkg::recip_mul(z_next, tsl_pkg::ERA_M, tsl_pkg::ERA_K);
    era_next    = p_era[3:0];
    doe_next    = 18'(c1_z - 21'(c1_era) * 21'(tsl_pkg::DAYS_PER_ERA));
    // Leap-day corrections inside the era, then the year of era.
    p1460       = tsl_pkg::recip_mul(21'(c2_doe), tsl_pkg::D1460_M, tsl_pkg::D1460_K);
    p36524      = tsl_pkg::recip_mul(21'(c2_doe), tsl_pkg::D36524_M, tsl_pkg::D36524_K);
    q1460_next  = p1460[7:0];
    q36524_next = p36524[2:0];
    full_next   = (c2_doe == 18'(tsl_pkg::DAYS_PER_ERA - 1));
    num_next    = c3_doe - 18'(c3_q1460) + 18'(c3_q36524) - 18'(c3_full);
    p365        = tsl_pkg::recip_mul(21'(c4_num), tsl_pkg::D365_M, tsl_pkg::D365_K);
    yoe_next    = p365[9:0];
    p100        = tsl_pkg::recip_mul(21'(c5_yoe), tsl_pkg::YOE100_M, tsl_pkg::YOE100_K);
    q100_next   = p100[3:0];
    // Day of the March-based year and the year itself.
    base        = 18'(c6_yoe) * 18'd365 + 18'(c6_yoe >> 2) - 18'(c6_q100);
    doy_next    = 9'(c6_doe - base);
    yr_next     = 14'(c6_yoe) + 14'(c6_era) * 14'd400;
    // Month index, counted from March, and the first day of that month.
    pmp         = tsl_pkg::recip_mul(21'(11'(c7_doy) * 11'd5 + 11'd2), tsl_pkg::MP_M,
                                     tsl_pkg::MP_K);
    mp_next     = pmp[3:0];
    pd5         = tsl_pkg::recip_mul(21'(11'(c8_mp) * 11'd153 + 11'd2), tsl_pkg::D5_M,
                                     tsl_pkg::D5_K);
    d5_next     = pd5[8:0];
    mm_next     = (c8_mp < 4'd10) ? c8_mp + 4'd3 : c8_mp - 4'd9;
    // January and February belong to the next calendar year.
    yr_adj          = c9_yr + 14'(c9_mm <= 4'd2);
    date_next.year  = yr_adj[11:0];
    date_next.month = c9_mm;
    date_next.day   = 5'(c9_doy - c9_d5 + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_z      <= z_next;
      c1_era    <= era_next;
      c2_doe    <= doe_next;
      c2_era    <= c1_era;
      c3_doe    <= c2_doe;
      c3_era    <= c2_era;
      c3_q1460  <= q1460_next;
      c3_q36524 <= q36524_next;
      c3_full   <= full_next;
      c4_num    <= num_next;
      c4_doe    <= c3_doe;
      c4_era    <= c3_era;
      c5_yoe    <= yoe_next;
      c5_doe    <= c4_doe;
      c5_era    <= c4_era;
      c6_yoe    <= c5_yoe;
      c6_doe    <= c5_doe;
      c6_era    <= c5_era;
      c6_q100   <= q100_next;
      c7_doy    <= doy_next;
      c7_yr     <= yr_next;
      c8_doy    <= c7_doy;
      c8_mp     <= mp_next;
      c8_yr     <= c7_yr;
      c9_doy    <= c8_doy;
      c9_d5     <= d5_next;
      c9_mm     <= mm_next;
      c9_yr     <= c8_yr;
      date      <= date_next;
      side_q[0] <= side_in;
      for (int i = 1; i < STAGES; i++) begin
        side_q[i] <= side_q[i - 1];
      end
    end
  end

  assign side_out = side_q[STAGES - 1];

endmodule

`default_nettype wire

// File: rtl/tsl_time_split.sv
// Three-stage split of the second of day into hour, minute and second, and
// the final output register with the minute count. Uses tsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsl_time_split (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire tsl_pkg::sod_t  side,
  input  wire tsl_pkg::date_t date,
  output logic [11:0]         year,
  output logic [3:0]          month,
  output logic [4:0]          day,
  output logic [4:0]          hour,
  output logic [5:0]          minute,
  output logic [5:0]          second,
  output logic [15:0]         day_minutes,
  output logic                clamped
);

  logic [10:0]    t1_a;
  logic [16:0]    secs_a;
  tsl_pkg::date_t date_a;
  logic           clamped_a;
  logic [10:0]    t1_b;
  logic [5:0]     sec_b;
  logic [4:0]     hr_b;
  tsl_pkg::date_t date_b;
  logic           clamped_b;

  logic [10:0] t1_next;
  logic [5:0]  sec_next;
  logic [4:0]  hr_next;
  logic [5:0]  min_next;
  logic [15:0] dm_next;

  always_comb begin
    logic [42:0] pt1;
    logic [42:0] phr;
    pt1      = tsl_pkg::recip_mul(21'(side.secs), tsl_pkg::DIV60_M, tsl_pkg::DIV60_K);
    t1_next  = pt1[10:0];
    sec_next = 6'(secs_a - 17'(t1_a) * 17'd60);
    phr      = tsl_pkg::recip_mul(21'(t1_a), tsl_pkg::HOUR_M, tsl_pkg::HOUR_K);
    hr_next  = phr[4:0];
    min_next = 6'(t1_b - 11'(hr_b) * 11'd60);
    // Hour times 60 plus minute is the minute of day itself.
    dm_next  = 16'(date_b.day) * 16'(tsl_pkg::MINS_PER_DAY) + 16'(t1_b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_a        <= t1_next;
      secs_a      <= side.secs;
      date_a      <= date;
      clamped_a   <= side.clamped;
      t1_b        <= t1_a;
      sec_b       <= sec_next;
      hr_b        <= hr_next;
      date_b      <= date_a;
      clamped_b   <= clamped_a;
      year        <= date_b.year;
      month       <= date_b.month;
      day         <= date_b.day;
      hour        <= hr_b;
      minute      <= min_next;
      second      <= sec_b;
      day_minutes <= dm_next;
      clamped     <= clamped_b;
    end
  end

endmodule

`default_nettype wire

// File: rtl/timestamp_to_fixed_local_time.sv
// An accepted item passes through the day count, normalize, civil date and time split stages to the output port.
// Throughput is one item per cycle; the whole pipeline holds while a result is stalled.
// Synchronous active-high reset clears all valid bits and loads the local offset
// with -360 minutes; data registers are not reset.
// Top level of the timestamp converter. Uses tsl_pkg and the tsl_* stage modules.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_to_fixed_local_time #(
  parameter int MAX_YEAR = 2399
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic signed [11:0] cfg_data,
  input  wire logic               src_valid,
  output logic                    src_stall,
  input  wire logic [11:0]        src_year,
  input  wire logic [3:0]         src_month,
  input  wire logic [4:0]         src_day,
  input  wire logic [4:0]         src_hour,
  input  wire logic [5:0]         src_minute,
  input  wire logic [5:0]         src_second,
  input  wire logic signed [11:0] src_offset_minutes,
  output logic                    local_valid,
  input  wire logic               local_stall,
  output logic [11:0]             local_year,
  output logic [3:0]              local_month,
  output logic [4:0]              local_day,
  output logic [4:0]              local_hour,
  output logic [5:0]              local_minute,
  output logic [5:0]              local_second,
  output logic [15:0]             day_minutes,
  output logic                    clamped
);

  // The pipeline is two stages of day counting, one of day/second
  // normalization with the epoch clamp, ten of civil date recovery and
  // three of time-of-day split, the last of which is the output register.
  localparam int LATENCY = 16;

  logic signed [11:0] local_offset;
  logic [LATENCY-1:0] vld;
  logic               en;

  logic signed [21:0] days;
  logic signed [19:0] sod;
  logic [19:0]        dn;
  tsl_pkg::sod_t      norm_side;
  tsl_pkg::sod_t      date_side;
  tsl_pkg::date_t     date;

  // The local offset must be written only while no item is in flight, so the
  // front stage may read it directly; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      local_offset <= tsl_pkg::RESET_LOCAL_OFFSET;
    end else if (cfg_write) begin
      local_offset <= cfg_data;
    end
  end

  // Every stage moves together. The pipe stops only when its last stage
  // holds a result that the receiver is stalling, so nothing is lost or
  // repeated, and bubbles simply travel as cleared valid bits.
  assign en          = !(vld[LATENCY-1] && local_stall);
  assign src_stall   = vld[LATENCY-1] && local_stall;
  assign local_valid = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], src_valid};
    end
  end

  // Days since 1970 and the signed second of day with both offsets applied.
  tsl_day_count #(
    .MAX_YEAR(MAX_YEAR)
  ) u_day_count (
    .clk          (clk),
    .en           (en),
    .year         (src_year),
    .month        (src_month),
    .day          (src_day),
    .hour         (src_hour),
    .minute       (src_minute),
    .second       (src_second),
    .src_offset   (src_offset_minutes),
    .local_offset (local_offset),
    .days         (days),
    .sod          (sod)
  );

  // Carry whole days out of the second of day; a negative day count means
  // the local time lies before the epoch and is saturated to it.
  tsl_normalize u_normalize (
    .clk  (clk),
    .en   (en),
    .days (days),
    .sod  (sod),
    .dn   (dn),
    .side (norm_side)
  );

  // Day number to calendar date with constant-reciprocal divisions.
  tsl_civil_date u_civil_date (
    .clk      (clk),
    .en       (en),
    .dn       (dn),
    .side_in  (norm_side),
    .date     (date),
    .side_out (date_side)
  );

  // Hour, minute, second and the minute count; its last stage drives the port.
  tsl_time_split u_time_split (
    .clk         (clk),
    .en          (en),
    .side        (date_side),
    .date        (date),
    .year        (local_year),
    .month       (local_month),
    .day         (local_day),
    .hour        (local_hour),
    .minute      (local_minute),
    .second      (local_second),
    .day_minutes (day_minutes),
    .clamped     (clamped)
  );

endmodule

`default_nettype wire

// File: rtl/tsl_checker.sv
// Port-level checks for timestamp_to_fixed_local_time and the bind that
// attaches them. Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module tsl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        src_stall,
  input wire logic        local_valid,
  input wire logic        local_stall,
  input wire logic [11:0] local_year,
  input wire logic [3:0]  local_month,
  input wire logic [4:0]  local_day,
  input wire logic [4:0]  local_hour,
  input wire logic [5:0]  local_minute,
  input wire logic [5:0]  local_second,
  input wire logic [15:0] day_minutes,
  input wire logic        clamped
);

  // A stalled result stays presented, with its date, minute count and clamp flag unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    local_valid && local_stall |=> local_valid && $stable(local_year) &&
      $stable(local_month) && $stable(local_day) && $stable(day_minutes) &&
      $stable(clamped))
    else $error("stalled result changed");

  // The input side is held back only by a stalled result at the output.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> local_valid && local_stall)
    else $error("input stalled without output backpressure");

  // A clamped result is exactly midnight of 1970-01-01.
  a_clamp_epoch: assert property (@(posedge clk) disable iff (rst)
    local_valid && clamped |-> local_year == 12'd1970 && local_month == 4'd1 &&
      local_day == 5'd1 && local_hour == 5'd0 && local_minute == 6'd0 &&
      local_second == 6'd0 && day_minutes == 16'd1440)
    else $error("clamped result is not the epoch");

  // The minute count agrees with the day, hour and minute fields.
  a_minutes: assert property (@(posedge clk) disable iff (rst)
    local_valid |-> day_minutes == 16'(local_day) * 16'd1440 +
      16'(local_hour) * 16'd60 + 16'(local_minute))
    else $error("day_minutes does not match the time fields");

  // Every result is a normalized local time.
  a_range: assert property (@(posedge clk) disable iff (rst)
    local_valid |-> local_month >= 4'd1 && local_month <= 4'd12 &&
      local_day >= 5'd1 && local_hour <= 5'd23 && local_minute <= 6'd59 &&
      local_second <= 6'd59)
    else $error("result field out of range");

endmodule

bind timestamp_to_fixed_local_time tsl_checker u_tsl_checker (
  .clk          (clk),
  .rst          (rst),
  .src_stall    (src_stall),
  .local_valid  (local_valid),
  .local_stall  (local_stall),
  .local_year   (local_year),
  .local_month  (local_month),
  .local_day    (local_day),
  .local_hour   (local_hour),
  .local_minute (local_minute),
  .local_second (local_second),
  .day_minutes  (day_minutes),
  .clamped      (clamped)
);

`default_nettype wire
